FILE: sv/half_float_add_sub_defines.svh
// Assertion macros shared by the half-precision adder RTL.
`ifndef HALF_FLOAT_ADD_SUB_DEFINES_SVH
`define HALF_FLOAT_ADD_SUB_DEFINES_SVH

`ifndef SYNTHESIS
`define HFAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HFAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HFAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define HFAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/hfas_pkg.sv
// Types, constants and helpers for the half-precision adder pipeline.
package hfas_pkg;

   localparam int EXP_W  = 5;
   localparam int MAN_W  = 10;
   localparam int GRD_W  = 3;
   localparam int EXT_W  = MAN_W + 1 + GRD_W;
   localparam int WORD_W = 1 + EXP_W + MAN_W;
   localparam logic [EXP_W-1:0] EXP_MAX = '1;

   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] operand_a;
      logic [WORD_W-1:0] operand_b;
   } hfas_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum_word;
      logic              exponent_clamped;
   } hfas_rsp_type;

   // Operands ordered by exponent, mantissas extended with hidden and guard bits.
   typedef struct packed {
      logic             lead_s;
      logic [EXP_W-1:0] lead_e;
      logic [EXT_W-1:0] lead_m;
      logic             trail_s;
      logic [EXT_W-1:0] trail_m;
      logic [EXP_W-1:0] diff;
   } hfas_swap_type;

   typedef struct packed {
      logic             lead_s;
      logic [EXP_W-1:0] lead_e;
      logic [EXT_W-1:0] lead_m;
      logic             trail_s;
      logic [EXT_W-1:0] trail_m;
   } hfas_align_type;

   typedef struct packed {
      logic             z_s;
      logic [EXP_W-1:0] z_e;
      logic [EXT_W:0]   z_m;
      logic             eff_sub;
      logic             is_zero;
   } hfas_sum_type;

   // Position of the highest set bit of a nonzero extended mantissa.
   function automatic logic [3:0] hfas_msb_index(input logic [EXT_W-1:0] v);
      logic [3:0] p;
      p = '0;
      for (int i = 0; i < EXT_W; i++) begin
         if (v[i]) begin
            p = 4'(i);
         end
      end
      return p;
   endfunction

endpackage

FILE: sv/hfas_swap.sv
// First stage: sign flip for subtract, operand ordering by exponent.
module hfas_swap import hfas_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          stage_en,
   input  logic          in_valid,
   input  hfas_req_type  in_data,
   output logic          out_valid,
   output hfas_swap_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   hfas_swap_type data_ff;
   hfas_swap_type data_in;

   logic [WORD_W-1:0] a_word;
   logic [WORD_W-1:0] b_word;
   logic [EXP_W-1:0]  a_e;
   logic [EXP_W-1:0]  b_e;
   logic              swap;

   always_comb begin
      a_word = in_data.operand_a;
      b_word = in_data.operand_b;
      b_word[WORD_W-1] = in_data.operand_b[WORD_W-1] ^ in_data.cmd;
      a_e = a_word[WORD_W-2:MAN_W];
      b_e = b_word[WORD_W-2:MAN_W];
      swap = b_e > a_e;
      if (swap) begin
         data_in.lead_s  = b_word[WORD_W-1];
         data_in.lead_e  = b_e;
         data_in.lead_m  = {1'b1, b_word[MAN_W-1:0], {GRD_W{1'b0}}};
         data_in.trail_s = a_word[WORD_W-1];
         data_in.trail_m = {1'b1, a_word[MAN_W-1:0], {GRD_W{1'b0}}};
         data_in.diff    = b_e - a_e;
      end else begin
         data_in.lead_s  = a_word[WORD_W-1];
         data_in.lead_e  = a_e;
         data_in.lead_m  = {1'b1, a_word[MAN_W-1:0], {GRD_W{1'b0}}};
         data_in.trail_s = b_word[WORD_W-1];
         data_in.trail_m = {1'b1, b_word[MAN_W-1:0], {GRD_W{1'b0}}};
         data_in.diff    = a_e - b_e;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/hfas_align.sv
// Second stage: right shift of the trailing mantissa with a sticky bit.
module hfas_align import hfas_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           stage_en,
   input  logic           in_valid,
   input  hfas_swap_type  in_data,
   output logic           out_valid,
   output hfas_align_type out_data
);

   logic           valid_ff;
   logic           valid_in;
   hfas_align_type data_ff;
   hfas_align_type data_in;

   logic [15:0]      trail_wide;
   logic [15:0]      lost_mask;
   logic [15:0]      kept;
   logic [EXT_W-1:0] shifted;

   always_comb begin
      trail_wide = {{(16-EXT_W){1'b0}}, in_data.trail_m};
      lost_mask  = ~(16'hffff << in_data.diff[3:0]);
      kept       = trail_wide >> in_data.diff[3:0];
      // A difference of sixteen or more leaves only the sticky bit.
      if (in_data.diff[4]) begin
         shifted = EXT_W'(1);
      end else begin
         shifted = kept[EXT_W-1:0] | EXT_W'(|(trail_wide & lost_mask));
      end
      data_in.lead_s  = in_data.lead_s;
      data_in.lead_e  = in_data.lead_e;
      data_in.lead_m  = in_data.lead_m;
      data_in.trail_s = in_data.trail_s;
      data_in.trail_m = shifted;
      valid_in        = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/hfas_addsub.sv
// Third stage: magnitude add, or subtract of the smaller from the larger.
module hfas_addsub import hfas_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           stage_en,
   input  logic           in_valid,
   input  hfas_align_type in_data,
   output logic           out_valid,
   output hfas_sum_type   out_data
);

   logic         valid_ff;
   logic         valid_in;
   hfas_sum_type data_ff;
   hfas_sum_type data_in;

   logic eff_sub;
   logic lead_bigger;

   always_comb begin
      eff_sub     = in_data.lead_s != in_data.trail_s;
      lead_bigger = in_data.lead_m > in_data.trail_m;
      data_in.z_e     = in_data.lead_e;
      data_in.eff_sub = eff_sub;
      data_in.is_zero = eff_sub && (in_data.lead_m == in_data.trail_m);
      if (!eff_sub) begin
         data_in.z_s = in_data.lead_s;
         data_in.z_m = {1'b0, in_data.lead_m} + {1'b0, in_data.trail_m};
      end else if (lead_bigger) begin
         data_in.z_s = in_data.lead_s;
         data_in.z_m = {1'b0, in_data.lead_m - in_data.trail_m};
      end else begin
         data_in.z_s = in_data.trail_s;
         data_in.z_m = {1'b0, in_data.trail_m - in_data.lead_m};
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/hfas_norm.sv
// Fourth stage: renormalisation, truncation, exponent clamping and packing.
module hfas_norm import hfas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         stage_en,
   input  logic         in_valid,
   input  hfas_sum_type in_data,
   output logic         out_valid,
   output hfas_rsp_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   hfas_rsp_type data_ff;
   hfas_rsp_type data_in;

   logic [3:0]       msb;
   logic [3:0]       lshift;
   logic [EXT_W-1:0] norm_m;
   logic [EXP_W:0]   exp_up;

   always_comb begin
      msb    = hfas_msb_index(in_data.z_m[EXT_W-1:0]);
      lshift = 4'(EXT_W - 1) - msb;
      norm_m = in_data.z_m[EXT_W-1:0] << lshift;
      exp_up = {1'b0, in_data.z_e} + (EXP_W+1)'(1);
      data_in.exponent_clamped = 1'b0;
      if (in_data.is_zero) begin
         // Exact cancellation always gives positive zero.
         data_in.sum_word = '0;
      end else if (!in_data.eff_sub) begin
         if (in_data.z_m[EXT_W]) begin
            if (exp_up[EXP_W]) begin
               data_in.sum_word         = {in_data.z_s, EXP_MAX, {MAN_W{1'b0}}};
               data_in.exponent_clamped = 1'b1;
            end else begin
               data_in.sum_word = {in_data.z_s, exp_up[EXP_W-1:0],
                                   in_data.z_m[EXT_W-1:GRD_W+1]};
            end
         end else begin
            data_in.sum_word = {in_data.z_s, in_data.z_e, in_data.z_m[EXT_W-2:GRD_W]};
         end
      end else if ({1'b0, in_data.z_e} < {{(EXP_W-3){1'b0}}, lshift}) begin
         data_in.sum_word         = {in_data.z_s, {(WORD_W-1){1'b0}}};
         data_in.exponent_clamped = 1'b1;
      end else begin
         data_in.sum_word = {in_data.z_s, in_data.z_e - EXP_W'(lshift),
                             norm_m[EXT_W-2:GRD_W]};
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/half_float_add_sub.sv
// Half-precision add/subtract with truncation: one word enters per cycle while
// req_ready is high and passes four register stages (operand ordering, mantissa
// alignment, magnitude add or subtract, renormalise and pack) before its result is
// presented. Each stage holds only while the stage after it is full and stalled, so
// empty slots close up and a result waiting at the output stops new words only once
// the three stages behind it are full.
// Overflow saturates to infinity and underflow flushes to signed zero, both with
// exponent_clamped set; exponent zero and exponent thirty-one are ordinary values.
module half_float_add_sub import hfas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  hfas_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hfas_rsp_type rsp_data
);

`include "half_float_add_sub_defines.svh"

   logic           v1, v2, v3;
   logic           en1, en2, en3, en4;
   hfas_swap_type  s1_data;
   hfas_align_type s2_data;
   hfas_sum_type   s3_data;

   logic [WORD_W-2:0] rsp_mag;
   logic              clamp_form_ok;

   assign en4       = !rsp_valid || rsp_ready;
   assign en3       = !v3 || en4;
   assign en2       = !v2 || en3;
   assign en1       = !v1 || en2;
   assign req_ready = en1;

   hfas_swap u_swap (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (en1),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (v1),
      .out_data  (s1_data)
   );

   hfas_align u_align (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (en2),
      .in_valid  (v1),
      .in_data   (s1_data),
      .out_valid (v2),
      .out_data  (s2_data)
   );

   hfas_addsub u_addsub (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (en3),
      .in_valid  (v2),
      .in_data   (s2_data),
      .out_valid (v3),
      .out_data  (s3_data)
   );

   hfas_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (en4),
      .in_valid  (v3),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_mag       = rsp_data.sum_word[WORD_W-2:0];
   assign clamp_form_ok = (rsp_mag == {EXP_MAX, {MAN_W{1'b0}}}) || (rsp_mag == '0);

   // A clamped word is either infinity or zero of either sign.
   `HFAS_ASSERT_SAME(a_clamp_form, clock, reset, rsp_valid && rsp_data.exponent_clamped, clamp_form_ok)
   // An accepted word always lands in the first stage.
   `HFAS_ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, v1)
   // A stalled first stage keeps its word.
   `HFAS_ASSERT_NEXT(a_hold1, clock, reset, v1 && !en2, v1 && $stable(s1_data))
   // A stalled third stage keeps its word.
   `HFAS_ASSERT_NEXT(a_hold3, clock, reset, v3 && !en4, v3 && $stable(s3_data))

endmodule
